// File: src/epp_pkg.sv
// Shared constants and controller/datapath handshake types for the
// edge partition padder. No dependencies.
package epp_pkg;

	localparam int PART_COUNT     = 16;
	localparam int PART_SPAN      = 524288;
	localparam int SRC_BUF_SPAN   = 65536;
	localparam int PART_SHIFT     = $clog2(PART_SPAN);
	localparam int SRC_BUF_SHIFT  = $clog2(SRC_BUF_SPAN);
	localparam int PART_W         = $clog2(PART_COUNT);

	localparam int VERTEX_W = 31;
	localparam int WORD_W   = 32;
	localparam int BUF_W    = 15;
	localparam int GROUP    = 8;
	localparam int GROUP_W  = $clog2(GROUP);
	localparam int PAD_W    = GROUP_W + 1;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 2;

	localparam logic KIND_EDGE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic load_in;
		logic eval_load;
		logic emit_pad;
		logic emit_edge;
		logic emit_err;
		logic clear_entry;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic flush_ok;
		logic dst_err;
		logic pad_zero;
		logic pads_one;
		logic out_free;
	} sts_t;

endpackage

// File: src/edge_partition_padder_top.sv
// Top level of the edge partition padder: joins the sequencer and the datapath.
// Depends on epp_pkg, epp_ctrl and epp_dp.
//
// Edges (src, dst) are sorted into partition dst >> 19 and sent out as word
// pairs tagged with their partition and running edge count. Each partition
// keeps its edge count, last source and last source buffer (src >> 16, low
// 15 bits); when an edge arrives from a new source buffer the partition is
// first padded with <last source, end_flag|MSB> until its edge count mod 8 is zero.
// A flush transaction closes one partition: if it holds edges, it emits
// 8 - (count mod 8) pseudo-edges <last source|MSB, end_flag|MSB> (eight when
// the count is already aligned) and the partition returns to its reset state.
// An edge whose partition is past the last one yields a single result with
// the error flag set and changes nothing. A plain edge is accepted, looked
// up in the table and emitted; pads go out between lookup and emit, and a
// flush ends with its last pad, which returns straight to accept. The
// sequencer emits one word pair per cycle through the single output register
// while that register is free. A flush of an empty partition ends after lookup. The
// output register decouples the two sides: a new input transaction is taken
// while the last result still waits for m_tready. The user must see that
// end_flag is written only while the block is idle; it is not enforced.
module edge_partition_padder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                end_flag_we,
	input  logic [epp_pkg::VERTEX_W-1:0]        end_flag_wdata,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: src_vertex[30:0], dst_vertex[61:31], flush_partition[65:62], zero fill
	input  logic [epp_pkg::IN_DATA_W-1:0]       s_tdata,
	// s_tuser: kind (0 edge, 1 flush)
	input  logic                                s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: partition[3:0], src_word[35:4], dst_word[67:36],
	//          edge_count[99:68], zero fill
	output logic [epp_pkg::OUT_DATA_W-1:0]      m_tdata,
	// m_tuser: is_padding[0], error[1]
	output logic [epp_pkg::OUT_USER_W-1:0]      m_tuser,
	// m_tlast: last result of the input transaction
	output logic                                m_tlast
);
	import epp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: steps each transaction through lookup, padding and emit
	epp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: partition table, pad counters and output register
	epp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.end_flag_we    (end_flag_we),
		.end_flag_wdata (end_flag_wdata),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

// File: src/epp_ctrl.sv
// Sequencer for the edge partition padder: load, look up, pad, emit.
// Depends on epp_pkg for the command and status types.
module epp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  epp_pkg::sts_t sts,
	output epp_pkg::cmd_t cmd
);
	import epp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_PAD  = 3'd2;
	localparam logic [2:0] S_EDGE = 3'd3;
	localparam logic [2:0] S_ERR  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval_load = 1'b1;
				priority if (sts.is_flush) begin
					state_d = sts.flush_ok ? S_PAD : S_IDLE;
				end else if (sts.dst_err) begin
					state_d = S_ERR;
				end else begin
					state_d = sts.pad_zero ? S_EDGE : S_PAD;
				end
			end
			S_PAD: begin
				if (sts.out_free) begin
					cmd.emit_pad = 1'b1;
					if (sts.pads_one) begin
						cmd.clear_entry = sts.is_flush;
						state_d         = sts.is_flush ? S_IDLE : S_EDGE;
					end
				end
			end
			S_EDGE: begin
				if (sts.out_free) begin
					cmd.emit_edge = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_pad, cmd.emit_edge, cmd.emit_err}))
		else $error("more than one emit command at once");

	a_err_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> state_q == S_IDLE)
		else $error("error result not followed by idle");

	a_clear_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_entry |-> (cmd.emit_pad && sts.is_flush && sts.pads_one))
		else $error("partition cleared outside the final flush pad");

endmodule

// File: src/epp_dp.sv
// Datapath of the edge partition padder: input holding registers, the
// per-partition state table, pad counters and the output register. Uses epp_pkg.
module epp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                end_flag_we,
	input  logic [epp_pkg::VERTEX_W-1:0]        end_flag_wdata,
	input  logic [epp_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [epp_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [epp_pkg::OUT_USER_W-1:0]      m_tuser,
	output logic                                m_tlast,
	input  epp_pkg::cmd_t                       cmd,
	output epp_pkg::sts_t                       sts
);
	import epp_pkg::*;

	logic [VERTEX_W-1:0] end_flag_q;

	// captured input transaction
	logic                kind_q;
	logic [VERTEX_W-1:0] src_q;
	logic [VERTEX_W-1:0] dst_q;
	logic [PART_W-1:0]   fp_q;

	// working registers for the current item
	logic [PART_W-1:0]   part_q;
	logic [WORD_W-1:0]   cnt_q;
	logic [PAD_W-1:0]    pads_q;
	logic [VERTEX_W-1:0] lsrc_q;

	// per-partition state
	logic [WORD_W-1:0]   tbl_cnt_q  [PART_COUNT];
	logic [VERTEX_W-1:0] tbl_lsrc_q [PART_COUNT];
	logic [BUF_W-1:0]    tbl_buf_q  [PART_COUNT];

	// output register
	logic                m_tvalid_q;
	logic [PART_W-1:0]   o_part_q;
	logic [WORD_W-1:0]   o_src_q;
	logic [WORD_W-1:0]   o_dst_q;
	logic [WORD_W-1:0]   o_cnt_q;
	logic                o_pad_q;
	logic                o_err_q;
	logic                o_last_q;

	logic [VERTEX_W-1:0] pid_full;
	logic [VERTEX_W-1:0] buf_full;
	logic [BUF_W-1:0]    src_buf;
	logic [PART_W-1:0]   idx;
	logic [WORD_W-1:0]   cnt_rd;
	logic [GROUP_W-1:0]  rem;
	logic [PAD_W-1:0]    pad_fill;
	logic [PAD_W-1:0]    pad_n;
	logic                flush_in_range;
	logic [WORD_W-1:0]   cnt_inc;

	assign pid_full       = dst_q >> PART_SHIFT;
	assign buf_full       = src_q >> SRC_BUF_SHIFT;
	assign src_buf        = buf_full[BUF_W-1:0];
	assign flush_in_range = (32'(fp_q) < PART_COUNT);
	assign idx            = (kind_q == KIND_FLUSH) ? fp_q : pid_full[PART_W-1:0];
	assign cnt_rd         = tbl_cnt_q[idx];
	assign rem            = cnt_rd[GROUP_W-1:0];
	assign pad_fill       = PAD_W'(GROUP) - {1'b0, rem};
	assign cnt_inc        = cnt_q + WORD_W'(1);

	always_comb begin
		priority if (kind_q == KIND_FLUSH) begin
			pad_n = pad_fill;
		end else if ((src_buf != tbl_buf_q[idx]) && (rem != '0)) begin
			pad_n = pad_fill;
		end else begin
			pad_n = '0;
		end
	end

	assign sts.is_flush = (kind_q == KIND_FLUSH);
	assign sts.flush_ok = flush_in_range && (cnt_rd != '0);
	assign sts.dst_err  = (32'(pid_full) >= PART_COUNT);
	assign sts.pad_zero = (pad_n == '0);
	assign sts.pads_one = (pads_q == PAD_W'(1));
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_flag_q <= '0;
		end else if (end_flag_we) begin
			end_flag_q <= end_flag_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= s_tuser;
			src_q  <= s_tdata[VERTEX_W-1:0];
			dst_q  <= s_tdata[2*VERTEX_W-1:VERTEX_W];
			fp_q   <= s_tdata[2*VERTEX_W+PART_W-1:2*VERTEX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_load) begin
			part_q <= idx;
			cnt_q  <= cnt_rd;
			pads_q <= pad_n;
			lsrc_q <= tbl_lsrc_q[idx];
		end else if (cmd.emit_pad) begin
			cnt_q  <= cnt_inc;
			pads_q <= pads_q - PAD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PART_COUNT; i++) begin
				tbl_cnt_q[i]  <= '0;
				tbl_lsrc_q[i] <= '0;
				tbl_buf_q[i]  <= '0;
			end
		end else if (cmd.emit_edge) begin
			tbl_cnt_q[part_q]  <= cnt_inc;
			tbl_lsrc_q[part_q] <= src_q;
			tbl_buf_q[part_q]  <= src_buf;
		end else if (cmd.clear_entry) begin
			tbl_cnt_q[part_q]  <= '0;
			tbl_lsrc_q[part_q] <= '0;
			tbl_buf_q[part_q]  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit_pad || cmd.emit_edge || cmd.emit_err) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_pad) begin
			o_part_q <= part_q;
			o_src_q  <= {sts.is_flush, lsrc_q};
			o_dst_q  <= {1'b1, end_flag_q};
			o_cnt_q  <= cnt_inc;
			o_pad_q  <= 1'b1;
			o_err_q  <= 1'b0;
			o_last_q <= sts.is_flush && sts.pads_one;
		end else if (cmd.emit_edge) begin
			o_part_q <= part_q;
			o_src_q  <= {1'b0, src_q};
			o_dst_q  <= {1'b0, dst_q};
			o_cnt_q  <= cnt_inc;
			o_pad_q  <= 1'b0;
			o_err_q  <= 1'b0;
			o_last_q <= 1'b1;
		end else if (cmd.emit_err) begin
			o_part_q <= '0;
			o_src_q  <= {1'b0, src_q};
			o_dst_q  <= {1'b0, dst_q};
			o_cnt_q  <= '0;
			o_pad_q  <= 1'b0;
			o_err_q  <= 1'b1;
			o_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, o_cnt_q, o_dst_q, o_src_q, o_part_q};
	assign m_tuser  = {o_err_q, o_pad_q};
	assign m_tlast  = o_last_q;

	a_flush_tail_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_pad_q && o_last_q) |-> (o_cnt_q[GROUP_W-1:0] == '0))
		else $error("final flush pad does not close a group of eight");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pad && sts.is_flush && sts.pads_one) |=> (m_tvalid_q && o_last_q))
		else $error("final flush pad not marked last");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_err_q) |-> (o_cnt_q == '0 && !o_pad_q && o_last_q))
		else $error("malformed error result");

endmodule
